/* design/hlfs_pkg.sv */
// Package for the header line field splitter.
// Holds the protocol constants, byte classes and the result record.
// No dependencies.
`default_nettype none
package hlfs_pkg;

    localparam logic [7:0] HDR_0    = 8'h7A;   // 'z'
    localparam logic [7:0] HDR_1    = 8'h70;   // 'p'
    localparam logic [7:0] HDR_2    = 8'h66;   // 'f'
    localparam logic [7:0] CR_BYTE  = 8'h0D;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] SEP_BYTE = 8'h2C;   // ','
    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam int MAX_LEN     = 256;
    localparam int TOKEN_CHARS = 5;
    localparam int NUM_FIELDS  = 4;
    localparam int OUT_FIELDS  = 4;

    localparam int FIELD_W = 40;
    localparam int COUNT_W = 3;
    localparam int CNT_W   = $clog2(MAX_LEN);
    localparam int SLOT_W  = $clog2(NUM_FIELDS + 1);
    localparam int IDX_W   = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int CHARS_W = $clog2(TOKEN_CHARS + 1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_SEP,
        CLS_CR,
        CLS_LF,
        CLS_HDR0,
        CLS_HDR1,
        CLS_HDR2,
        CLS_TEXT
    } t_class;

    typedef struct packed {
        logic [7:0] rx_byte;
        t_class     cls;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] field_a;
        logic [FIELD_W-1:0] field_b;
        logic [FIELD_W-1:0] field_c;
        logic [FIELD_W-1:0] field_d;
        logic [COUNT_W-1:0] token_count;
        logic               extra_tokens;
    } t_result;

endpackage
`default_nettype wire

/* design/hlfs_fifo.sv */
// Short queue of classified bytes between front and back.
// Depends on hlfs_pkg (t_item, QUEUE_DEPTH).
`default_nettype none
module hlfs_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire hlfs_pkg::t_item i_wr_data,
    output logic                o_full,
    input  wire logic           i_rd,
    output hlfs_pkg::t_item     o_rd_data,
    output logic                o_empty
);

    hlfs_pkg::t_item                  r_mem [hlfs_pkg::QUEUE_DEPTH];
    logic [hlfs_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [hlfs_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [hlfs_pkg::QCNT_W-1:0]      r_cnt;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full    = (r_cnt == hlfs_pkg::QCNT_W'(hlfs_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == hlfs_pkg::QPTR_W'(hlfs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == hlfs_pkg::QPTR_W'(hlfs_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hlfs_pkg::QCNT_W'(hlfs_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a write");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule
`default_nettype wire

/* design/hlfs_front.sv */
// Front end: accepts received bytes and tags each with its byte class.
// Depends on hlfs_pkg (t_item, t_class, byte constants).
`default_nettype none
module hlfs_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [7:0]   i_rx_byte,
    output logic              o_wr,
    output hlfs_pkg::t_item   o_wr_data,
    input  wire logic         i_q_full
);

    logic            r_valid;
    logic            n_valid;
    hlfs_pkg::t_item r_item;
    hlfs_pkg::t_item n_item;
    logic            accept;

    assign o_full    = r_valid && i_q_full;
    assign accept    = i_push && !o_full;
    assign o_wr      = r_valid;
    assign o_wr_data = r_item;

    always_comb begin
        n_item.rx_byte = i_rx_byte;
        unique case (i_rx_byte)
            hlfs_pkg::NUL_BYTE: n_item.cls = hlfs_pkg::CLS_NUL;
            hlfs_pkg::SEP_BYTE: n_item.cls = hlfs_pkg::CLS_SEP;
            hlfs_pkg::CR_BYTE:  n_item.cls = hlfs_pkg::CLS_CR;
            hlfs_pkg::LF_BYTE:  n_item.cls = hlfs_pkg::CLS_LF;
            hlfs_pkg::HDR_0:    n_item.cls = hlfs_pkg::CLS_HDR0;
            hlfs_pkg::HDR_1:    n_item.cls = hlfs_pkg::CLS_HDR1;
            hlfs_pkg::HDR_2:    n_item.cls = hlfs_pkg::CLS_HDR2;
            default:            n_item.cls = hlfs_pkg::CLS_TEXT;
        endcase
        n_valid = accept || (r_valid && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* design/hlfs_back.sv */
// Back end: line framing, token splitting and the result register.
// Depends on hlfs_pkg (t_item, t_result, limits).
`default_nettype none
module hlfs_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  wire hlfs_pkg::t_item i_item,
    output logic              o_rd,
    input  wire logic         i_pop,
    output logic              o_empty,
    output hlfs_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LOAD,
        PH_CR
    } t_phase;

    t_phase                          r_phase,    n_phase;
    logic [1:0]                      r_hdr_pos,  n_hdr_pos;
    logic [hlfs_pkg::CNT_W-1:0]      r_cnt,      n_cnt;
    logic [hlfs_pkg::FIELD_W-1:0]    r_store [hlfs_pkg::NUM_FIELDS];
    logic [hlfs_pkg::FIELD_W-1:0]    n_store [hlfs_pkg::NUM_FIELDS];
    logic [hlfs_pkg::SLOT_W-1:0]     r_slot,     n_slot;
    logic [hlfs_pkg::CHARS_W-1:0]    r_chars,    n_chars;
    logic                            r_ended,    n_ended;
    logic                            r_extra,    n_extra;
    logic                            r_out_valid, n_out_valid;
    hlfs_pkg::t_result               r_out,      n_out;

    logic                            go;
    logic                            produce;
    logic                            clear;
    logic [hlfs_pkg::SLOT_W:0]       cnt_sum;
    logic [hlfs_pkg::FIELD_W-1:0]    fld [hlfs_pkg::OUT_FIELDS];

    assign go       = !i_q_empty && (!r_out_valid || i_pop);
    assign o_rd     = go;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        for (int k = 0; k < hlfs_pkg::OUT_FIELDS; k++) begin
            fld[k] = (k < hlfs_pkg::NUM_FIELDS) ? r_store[k] : '0;
        end
        cnt_sum = (hlfs_pkg::SLOT_W + 1)'(r_slot) + ((r_chars != '0) ? 1'b1 : 1'b0);
        if (cnt_sum > (hlfs_pkg::SLOT_W + 1)'(hlfs_pkg::NUM_FIELDS)) begin
            cnt_sum = (hlfs_pkg::SLOT_W + 1)'(hlfs_pkg::NUM_FIELDS);
        end
        if (cnt_sum > (hlfs_pkg::SLOT_W + 1)'(hlfs_pkg::OUT_FIELDS)) begin
            cnt_sum = (hlfs_pkg::SLOT_W + 1)'(hlfs_pkg::OUT_FIELDS);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_cnt     = r_cnt;
        n_store   = r_store;
        n_slot    = r_slot;
        n_chars   = r_chars;
        n_ended   = r_ended;
        n_extra   = r_extra;
        produce   = 1'b0;
        clear     = 1'b0;

        if (go) begin
            unique case (r_phase)
                PH_LOAD: begin
                    if (i_item.cls == hlfs_pkg::CLS_CR) begin
                        n_phase = PH_CR;
                    end else begin
                        if (!r_ended) begin
                            case (i_item.cls)
                                hlfs_pkg::CLS_NUL: n_ended = 1'b1;
                                hlfs_pkg::CLS_SEP: begin
                                    if (r_chars != '0) begin
                                        if (r_slot < hlfs_pkg::SLOT_W'(hlfs_pkg::NUM_FIELDS)) begin
                                            n_slot = r_slot + 1'b1;
                                        end
                                        n_chars = '0;
                                    end
                                end
                                default: begin
                                    if (r_chars == '0 &&
                                        r_slot >= hlfs_pkg::SLOT_W'(hlfs_pkg::NUM_FIELDS)) begin
                                        n_extra = 1'b1;
                                    end
                                    if (r_slot < hlfs_pkg::SLOT_W'(hlfs_pkg::NUM_FIELDS) &&
                                        r_chars < hlfs_pkg::CHARS_W'(hlfs_pkg::TOKEN_CHARS)) begin
                                        for (int i = 0; i < hlfs_pkg::TOKEN_CHARS; i++) begin
                                            if (r_chars == hlfs_pkg::CHARS_W'(i) && 8 * i < hlfs_pkg::FIELD_W) begin
                                                n_store[r_slot[hlfs_pkg::IDX_W-1:0]][8*i +: 8] =
                                                    i_item.rx_byte;
                                            end
                                        end
                                    end
                                    if (r_chars < hlfs_pkg::CHARS_W'(hlfs_pkg::TOKEN_CHARS)) begin
                                        n_chars = r_chars + 1'b1;
                                    end
                                end
                            endcase
                        end
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt == hlfs_pkg::CNT_W'(hlfs_pkg::MAX_LEN - 1)) begin
                            clear   = 1'b1;
                            n_phase = PH_HUNT;
                        end
                    end
                end
                PH_CR: begin
                    produce   = (i_item.cls == hlfs_pkg::CLS_LF);
                    clear     = 1'b1;
                    n_phase   = PH_HUNT;
                    n_hdr_pos = 2'd0;
                end
                default: begin
                    // hunting; the spare phase code behaves the same
                    n_phase = PH_HUNT;
                    if (r_hdr_pos == 2'd0 && i_item.cls == hlfs_pkg::CLS_HDR0) begin
                        n_hdr_pos = 2'd1;
                    end else if (r_hdr_pos == 2'd1 && i_item.cls == hlfs_pkg::CLS_HDR1) begin
                        n_hdr_pos = 2'd2;
                    end else if (r_hdr_pos == 2'd2 && i_item.cls == hlfs_pkg::CLS_HDR2) begin
                        n_hdr_pos = 2'd0;
                        clear     = 1'b1;
                        n_phase   = PH_LOAD;
                    end else begin
                        n_hdr_pos = 2'd0;
                    end
                end
            endcase
        end

        if (clear) begin
            n_cnt   = '0;
            n_slot  = '0;
            n_chars = '0;
            n_ended = 1'b0;
            n_extra = 1'b0;
            for (int k = 0; k < hlfs_pkg::NUM_FIELDS; k++) begin
                n_store[k] = '0;
            end
        end

        n_out.field_a      = fld[0];
        n_out.field_b      = fld[1];
        n_out.field_c      = fld[2];
        n_out.field_d      = fld[3];
        n_out.token_count  = hlfs_pkg::COUNT_W'(cnt_sum);
        n_out.extra_tokens = r_extra;

        if (produce) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_hdr_pos   <= 2'd0;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_chars     <= '0;
            r_ended     <= 1'b0;
            r_extra     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < hlfs_pkg::NUM_FIELDS; k++) begin
                r_store[k] <= '0;
            end
        end else begin
            r_phase     <= n_phase;
            r_hdr_pos   <= n_hdr_pos;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_chars     <= n_chars;
            r_ended     <= n_ended;
            r_extra     <= n_extra;
            r_out_valid <= n_out_valid;
            r_store     <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot <= hlfs_pkg::SLOT_W'(hlfs_pkg::NUM_FIELDS)) &&
        (r_chars <= hlfs_pkg::CHARS_W'(hlfs_pkg::TOKEN_CHARS)))
        else $error("token slot or char count out of range");
    a_result_from_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce |-> (r_phase == PH_CR))
        else $error("result outside the after-CR phase");
    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOAD) |-> (r_hdr_pos == 2'd0))
        else $error("header position left set during payload");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |-> !go)
        else $error("back end advanced over a waiting result");
`endif

endmodule
`default_nettype wire

/* design/header_line_field_splitter_unit.sv */
// Top level of the header line field splitter.
// Depends on hlfs_pkg, hlfs_front, hlfs_fifo and hlfs_back.
//
// Usage:
//   Input channel: one received byte per transaction on i_rx_byte, taken at
//   a rising edge with push high and full low. Result channel: one
//   transaction per complete "zpf" line (payload, CR, LF); the result sits on
//   the o_ ports while empty is low and leaves at an edge with pop high.
//   Each result carries the first four comma separated tokens (five chars
//   each, first char in the low byte, zero padded), the token count capped
//   at four and a flag for surplus tokens.
// Path: the LF byte passes the front register and the queue; the back end
//   then loads the result register as it takes that byte.
// Throughput: one byte per cycle while no result waits untaken; each byte
//   is a single step of the back end's framing logic, and the front accepts
//   while the queue has room.
// Stalls: if a result waits untaken, the back end holds; the queue and the
//   front register fill, then full rises. Full never depends combinationally
//   on pop.
// Reset: i_rst_n low at a clock edge returns to header hunting with empty
//   queues, no waiting result and cleared token fields.
`default_nettype none
module header_line_field_splitter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [hlfs_pkg::FIELD_W-1:0]         o_field_a,
    output logic [hlfs_pkg::FIELD_W-1:0]         o_field_b,
    output logic [hlfs_pkg::FIELD_W-1:0]         o_field_c,
    output logic [hlfs_pkg::FIELD_W-1:0]         o_field_d,
    output logic [hlfs_pkg::COUNT_W-1:0]         o_token_count,
    output logic                                 o_extra_tokens
);

    // front -> queue
    logic              q_wr;
    hlfs_pkg::t_item   q_wr_data;
    logic              q_full;
    // queue -> back
    logic              q_rd;
    hlfs_pkg::t_item   q_rd_data;
    logic              q_empty;
    hlfs_pkg::t_result result;

    hlfs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_rx_byte (i_rx_byte),
        .o_wr      (q_wr),
        .o_wr_data (q_wr_data),
        .i_q_full  (q_full)
    );

    hlfs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    hlfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_rd_data),
        .o_rd      (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    // Unpack the result record onto its ports.
    assign o_field_a      = result.field_a;
    assign o_field_b      = result.field_b;
    assign o_field_c      = result.field_c;
    assign o_field_d      = result.field_d;
    assign o_token_count  = result.token_count;
    assign o_extra_tokens = result.extra_tokens;

endmodule
`default_nettype wire
